/* src/svss_pkg.sv */
// Shared types, constants and glyph lookup for the signed seven-segment converter.
// No dependencies; imported by every module of the block.
`default_nettype none

package svss_pkg;

   localparam int unsigned READING_W = 16;
   localparam int unsigned SEG_W     = 7;
   localparam int unsigned LOW3_W    = 10;
   localparam int unsigned REM_W     = 7;
   localparam int unsigned DIGIT_W   = 4;

   // floor(mag * RECIP_1000 / 2**RECIP_SHIFT) == mag / 1000 for mag <= 32768
   localparam logic [15:0] RECIP_1000  = 16'd33555;
   localparam int unsigned RECIP_SHIFT = 25;

   localparam logic [SEG_W-1:0] SEG_BLANK = 7'h00;
   localparam logic [SEG_W-1:0] SEG_MINUS = 7'h40;
   localparam logic [SEG_W-1:0] SEG_C     = 7'h39;

   typedef struct packed {
      logic neg;
      logic temp;
      logic small_mag;
   } side_type;

   function automatic logic [SEG_W-1:0] digit_glyph(input logic [DIGIT_W-1:0] d);
      logic [SEG_W-1:0] g;
      case (d)
         4'd0:    g = 7'h3f;
         4'd1:    g = 7'h06;
         4'd2:    g = 7'h5b;
         4'd3:    g = 7'h4f;
         4'd4:    g = 7'h66;
         4'd5:    g = 7'h6d;
         4'd6:    g = 7'h7d;
         4'd7:    g = 7'h07;
         4'd8:    g = 7'h7f;
         4'd9:    g = 7'h6f;
         default: g = SEG_BLANK;
      endcase
      return g;
   endfunction

endpackage

`default_nettype wire

/* src/svss_mag.sv */
// Magnitude and modulo-1000 stages: sign strip, reciprocal multiply, remainder.
// Depends on svss_pkg.
`default_nettype none

module svss_mag (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     in_valid,
   input  wire logic [15:0]              reading,
   input  wire logic                     is_temperature,
   output logic                          out_valid,
   output logic [9:0]                    low3,
   output svss_pkg::side_type            side
);
   import svss_pkg::*;

   // stage 1: magnitude
   logic                 v1_ff, v1_in;
   logic [READING_W-1:0] mag1_ff, mag1_in;
   side_type             side1_ff, side1_in;

   // stage 2: reciprocal product
   logic                 v2_ff;
   logic [READING_W-1:0] mag2_ff;
   logic [31:0]          prod2_ff, prod2_in;
   side_type             side2_ff;

   // stage 3: remainder
   logic                 v3_ff;
   logic [LOW3_W-1:0]    low3_ff, low3_in;
   side_type             side3_ff;

   logic [6:0]           quot;

   always_comb begin
      v1_in              = in_valid;
      mag1_in            = reading[15] ? (~reading + 16'd1) : reading;
      side1_in.neg       = reading[15];
      side1_in.temp      = is_temperature;
      side1_in.small_mag = (mag1_in < 16'd100);
   end

   assign prod2_in = 32'(mag1_ff) * 32'(RECIP_1000);
   assign quot     = prod2_ff[31:RECIP_SHIFT];
   assign low3_in  = LOW3_W'(mag2_ff - 16'(quot) * 16'd1000);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      mag1_ff  <= mag1_in;
      side1_ff <= side1_in;
      mag2_ff  <= mag1_ff;
      prod2_ff <= prod2_in;
      side2_ff <= side1_ff;
      low3_ff  <= low3_in;
      side3_ff <= side2_ff;
   end

   assign out_valid = v3_ff;
   assign low3      = low3_ff;
   assign side      = side3_ff;

endmodule

`default_nettype wire

/* src/svss_digits.sv */
// Digit split and glyph stages: hundreds, then tens/ones and cell assembly.
// Depends on svss_pkg.
`default_nettype none

module svss_digits (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     in_valid,
   input  wire logic [9:0]               low3,
   input  wire svss_pkg::side_type       side,
   output logic                          out_valid,
   output logic [6:0]                    cell_first,
   output logic [6:0]                    cell_second,
   output logic [6:0]                    cell_third,
   output logic [6:0]                    cell_fourth
);
   import svss_pkg::*;

   // stage 4: hundreds digit and remainder
   logic               v4_ff;
   logic [DIGIT_W-1:0] hund4_ff, hund4_in;
   logic [REM_W-1:0]   rem4_ff, rem4_in;
   side_type           side4_ff;
   logic [15:0]        hprod;

   // stage 5: output register
   logic               v5_ff;
   logic [SEG_W-1:0]   c0_ff, c0_in, c1_ff, c1_in, c2_ff, c2_in, c3_ff, c3_in;
   logic [14:0]        tprod;
   logic [DIGIT_W-1:0] tens, ones;
   logic [SEG_W-1:0]   gh, gt, go;

   // x * 41 >> 12 == x / 100 for x < 1000
   assign hprod    = 16'(low3) * 16'd41;
   assign hund4_in = hprod[15:12];
   assign rem4_in  = REM_W'(low3 - 10'(hund4_in) * 10'd100);

   // x * 205 >> 11 == x / 10 for x < 100
   assign tprod = 15'(rem4_ff) * 15'd205;
   assign tens  = tprod[14:11];
   assign ones  = DIGIT_W'(rem4_ff - 7'(tens) * 7'd10);
   assign gh    = digit_glyph(hund4_ff);
   assign gt    = digit_glyph(tens);
   assign go    = digit_glyph(ones);

   always_comb begin
      if (side4_ff.neg) begin
         c0_in = side4_ff.small_mag ? SEG_BLANK : SEG_MINUS;
         c1_in = side4_ff.small_mag ? SEG_MINUS : gh;
         c2_in = gt;
         c3_in = go;
      end else begin
         c0_in = side4_ff.small_mag ? SEG_BLANK : gh;
         c1_in = gt;
         c2_in = go;
         c3_in = side4_ff.temp ? SEG_C : SEG_BLANK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         v4_ff <= in_valid;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      hund4_ff <= hund4_in;
      rem4_ff  <= rem4_in;
      side4_ff <= side;
      c0_ff    <= c0_in;
      c1_ff    <= c1_in;
      c2_ff    <= c2_in;
      c3_ff    <= c3_in;
   end

   assign out_valid   = v5_ff;
   assign cell_first  = c0_ff;
   assign cell_second = c1_ff;
   assign cell_third  = c2_ff;
   assign cell_fourth = c3_ff;

endmodule

`default_nettype wire

/* src/signed_value_to_seven_segment.sv */
// Top level of the signed reading to seven-segment converter.
// Depends on svss_pkg, svss_mag and svss_digits.
//
// Takes one reading per clock: a transfer happens when start is high and busy is low,
// and busy is high only while reset is held. Each result appears on the rsp_ ports for
// exactly one cycle, marked by rsp_valid; the receiver cannot stall, so results must be
// taken when shown. Each reading passes through five register stages: magnitude,
// reciprocal multiply by 1/1000, remainder, hundreds split, and tens/ones split with
// glyph selection into the output register.
`default_nettype none

module signed_value_to_seven_segment (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [15:0] req_reading,
   input  wire logic        req_is_temperature,
   output logic             rsp_valid,
   output logic [6:0]       rsp_cell_first,
   output logic [6:0]       rsp_cell_second,
   output logic [6:0]       rsp_cell_third,
   output logic [6:0]       rsp_cell_fourth
);
   import svss_pkg::*;

   logic        mid_valid;
   logic [9:0]  mid_low3;
   side_type    mid_side;
   logic        accept;

   assign busy   = reset;
   assign accept = start && !busy;

   svss_mag u_mag (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (accept),
      .reading        (req_reading),
      .is_temperature (req_is_temperature),
      .out_valid      (mid_valid),
      .low3           (mid_low3),
      .side           (mid_side)
   );

   svss_digits u_digits (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (mid_valid),
      .low3        (mid_low3),
      .side        (mid_side),
      .out_valid   (rsp_valid),
      .cell_first  (rsp_cell_first),
      .cell_second (rsp_cell_second),
      .cell_third  (rsp_cell_third),
      .cell_fourth (rsp_cell_fourth)
   );

   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##5 rsp_valid)
      else $error("accepted transfer did not produce a result after five cycles");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, 5))
      else $error("result without a matching accepted transfer");

   a_mid_remainder: assert property (@(posedge clock) disable iff (reset)
      mid_valid |-> (mid_low3 < 10'd1000))
      else $error("modulo-1000 remainder out of range");

   a_suffix_sign: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_cell_fourth == SEG_C) |-> (rsp_cell_first != SEG_MINUS))
      else $error("temperature suffix shown together with a minus sign");

endmodule

`default_nettype wire

/* sim/signed_value_to_seven_segment_tb.sv */
// Self-checking testbench for signed_value_to_seven_segment: drives readings through the
// start/busy handshake and checks every rsp_valid strobe against a local display predictor.
// Depends on svss_pkg and the signed_value_to_seven_segment RTL.
`timescale 1ns / 1ps

module signed_value_to_seven_segment_tb;
   import svss_pkg::*;

   typedef struct packed {
      logic [6:0] first;
      logic [6:0] second;
      logic [6:0] third;
      logic [6:0] fourth;
   } cells_type;

   class segment_scoreboard;
      logic [6:0]  numeral_seg [10] = '{7'h3f, 7'h06, 7'h5b, 7'h4f, 7'h66,
                                        7'h6d, 7'h7d, 7'h07, 7'h7f, 7'h6f};
      cells_type   pending_cells [$];
      int unsigned failures = 0;

      // Predicts the four cells for one accepted reading and queues them.
      function void note_reading(logic [15:0] reading, logic is_temp);
         logic        neg;
         logic [16:0] mag;
         int unsigned low3;
         logic [6:0]  hund, tens, ones;
         logic        below_100;
         cells_type   c;
         neg       = reading[15];
         mag       = neg ? 17'h10000 - {1'b0, reading} : {1'b0, reading};
         low3      = mag % 1000;
         hund      = numeral_seg[low3 / 100];
         tens      = numeral_seg[(low3 / 10) % 10];
         ones      = numeral_seg[low3 % 10];
         below_100 = mag < 100;
         if (neg) begin
            c.first  = below_100 ? SEG_BLANK : SEG_MINUS;
            c.second = below_100 ? SEG_MINUS : hund;
            c.third  = tens;
            c.fourth = ones;
         end else begin
            c.first  = below_100 ? SEG_BLANK : hund;
            c.second = tens;
            c.third  = ones;
            c.fourth = is_temp ? SEG_C : SEG_BLANK;
         end
         pending_cells.push_back(c);
      endfunction

      function void compare_cell(string name, logic [6:0] want, logic [6:0] got);
         if (got !== want) begin
            $error("%s: expected %h, actual %h", name, want, got);
            failures++;
         end
      endfunction

      function void check_cells(cells_type got);
         cells_type want;
         if (pending_cells.size() == 0) begin
            $error("result with no pending reading: %h %h %h %h",
                   got.first, got.second, got.third, got.fourth);
            failures++;
            return;
         end
         want = pending_cells.pop_front();
         compare_cell("cell_first", want.first, got.first);
         compare_cell("cell_second", want.second, got.second);
         compare_cell("cell_third", want.third, got.third);
         compare_cell("cell_fourth", want.fourth, got.fourth);
      endfunction
   endclass

   localparam int STALL_LIMIT = 1000;

   logic        clock;
   logic        reset              = 1'b1;
   logic        start              = 1'b0;
   logic [15:0] req_reading        = '0;
   logic        req_is_temperature = 1'b0;
   logic        busy;
   logic        rsp_valid;
   logic [6:0]  rsp_cell_first, rsp_cell_second, rsp_cell_third, rsp_cell_fourth;

   segment_scoreboard sb = new();
   int unsigned       idle_pct = 0;
   int unsigned       quiet_cycles = 0;

   signed_value_to_seven_segment u_top (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_reading        (req_reading),
      .req_is_temperature (req_is_temperature),
      .rsp_valid          (rsp_valid),
      .rsp_cell_first     (rsp_cell_first),
      .rsp_cell_second    (rsp_cell_second),
      .rsp_cell_third     (rsp_cell_third),
      .rsp_cell_fourth    (rsp_cell_fourth)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Transfer monitor and watchdog; values read here are the pre-edge ones.
   always @(posedge clock) begin
      if (start && !busy)
         sb.note_reading(req_reading, req_is_temperature);
      if (rsp_valid)
         sb.check_cells({rsp_cell_first, rsp_cell_second, rsp_cell_third, rsp_cell_fourth});
      if ((start && !busy) || rsp_valid)
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("signed_value_to_seven_segment regression: fail");
         $finish;
      end
   end

   task automatic send_reading(input logic [15:0] value, input logic is_temp);
      while ($urandom_range(99, 0) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start              <= 1'b1;
      req_reading        <= value;
      req_is_temperature <= is_temp;
      do @(posedge clock); while (!(start && !busy));
   endtask

   task automatic run_phase(input int unsigned count, input int unsigned pct);
      int r;
      idle_pct = pct;
      repeat (count) begin
         case ($urandom_range(3, 0))
            0: begin
               r = int'($urandom_range(12, 0)) + 94;
               if ($urandom_range(1, 0)) r = -r;
            end
            1: r = int'($urandom_range(250, 0)) - 125;
            2: r = (int'($urandom_range(65, 0)) - 32) * 1000 + int'($urandom_range(4, 0)) - 2;
            default: r = int'($urandom);
         endcase
         send_reading(16'(r), 1'($urandom_range(1, 0)));
      end
   endtask

   initial begin
      int directed [12];
      directed = '{0, 99, 100, 999, 1000, 1099, 32767,
                   -1, -99, -100, -1000, -32768};
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) begin
         send_reading(16'(directed[i]), 1'b1);
         send_reading(16'(directed[i]), 1'b0);
      end

      run_phase(470, 0);
      run_phase(470, 63);
      run_phase(470, 9);
      run_phase(470, 0);
      start <= 1'b0;

      while (sb.pending_cells.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (sb.failures == 0)
         $display("signed_value_to_seven_segment regression: pass");
      else
         $display("signed_value_to_seven_segment regression: fail");
      $finish;
   end

endmodule
